FILE: sv/bca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bca_pkg
// Shared types, register indexes and arithmetic helpers for the barometric
// compensation and altitude pipeline.
// ----------------------------------------------------------------------------
package bca_pkg;

   localparam int DivWidth = 32;
   localparam int CsrIndexWidth = 3;

   localparam logic [CsrIndexWidth-1:0] CsrOss   = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CsrCalA  = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CsrCalB  = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CsrCalC  = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CsrExtra = 3'd4;

   typedef struct packed {
      logic [1:0]  oss;
      logic        ep;
      logic [31:0] ac1;
      logic [31:0] ac2;
      logic [31:0] ac3;
      logic [31:0] ac4;
      logic [31:0] ac5;
      logic [31:0] ac6;
      logic [31:0] b1;
      logic [31:0] b2;
      logic [31:0] mc;
      logic [31:0] md;
   } cfg_type;

   typedef struct packed {
      logic [31:0] x1;
      logic [18:0] up;
      logic        neg;
      logic        dz;
   } front_type;

   typedef struct packed {
      logic [15:0] temp;
      logic        dz;
      logic        b4z;
      logic        dbl;
   } mid_type;

   function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned s);
      return 32'($signed(v) >>> s);
   endfunction

   function automatic logic [15:0] sat_temp(input logic [31:0] v);
      if ($signed(v) < -32'sd32768) return 16'h8000;
      else if ($signed(v) > 32'sd32767) return 16'h7FFF;
      else return v[15:0];
   endfunction

   function automatic logic [19:0] sat_press(input logic [31:0] v);
      if (v[31]) return 20'd0;
      else if (v > 32'd1048575) return 20'hFFFFF;
      else return v[19:0];
   endfunction

   function automatic logic [24:0] sat_alt(input logic [31:0] v);
      if ($signed(v) < -32'sd16777216) return 25'h1000000;
      else if ($signed(v) > 32'sd16777215) return 25'h0FFFFFF;
      else return v[24:0];
   endfunction

endpackage

FILE: sv/bca_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bca_div
// Pipelined unsigned restoring divider, one quotient bit per stage, with a
// sideband word that travels alongside each beat.
// ----------------------------------------------------------------------------
module bca_div #(
   parameter int SideWidth = 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  logic [bca_pkg::DivWidth-1:0]    in_num,
   input  logic [bca_pkg::DivWidth-1:0]    in_den,
   input  logic [SideWidth-1:0]            in_side,
   output logic                            out_valid,
   output logic [bca_pkg::DivWidth-1:0]    out_quo,
   output logic [SideWidth-1:0]            out_side
);
   import bca_pkg::*;

   logic [DivWidth-1:0]  rem_ff  [DivWidth];
   logic [DivWidth-1:0]  num_ff  [DivWidth];
   logic [DivWidth-1:0]  den_ff  [DivWidth];
   logic [SideWidth-1:0] side_ff [DivWidth];
   logic [DivWidth-1:0]  vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DivWidth-2:0], in_valid};
      end
   end

   for (genvar i = 0; i < DivWidth; i++) begin : g_stage
      logic [DivWidth-1:0]  rem_src;
      logic [DivWidth-1:0]  num_src;
      logic [DivWidth-1:0]  den_src;
      logic [SideWidth-1:0] side_src;
      logic [DivWidth:0]    trial;
      logic [DivWidth:0]    diff;
      logic                 ge;

      if (i == 0) begin : g_first
         assign rem_src  = '0;
         assign num_src  = in_num;
         assign den_src  = in_den;
         assign side_src = in_side;
      end else begin : g_next
         assign rem_src  = rem_ff[i-1];
         assign num_src  = num_ff[i-1];
         assign den_src  = den_ff[i-1];
         assign side_src = side_ff[i-1];
      end

      assign trial = {rem_src, num_src[DivWidth-1]};
      assign diff  = trial - {1'b0, den_src};
      assign ge    = trial >= {1'b0, den_src};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= ge ? diff[DivWidth-1:0] : trial[DivWidth-1:0];
            num_ff[i]  <= {num_src[DivWidth-2:0], ge};
            den_ff[i]  <= den_src;
            side_ff[i] <= side_src;
         end
      end
   end

   assign out_valid = vld_ff[DivWidth-1];
   assign out_quo   = num_ff[DivWidth-1];
   assign out_side  = side_ff[DivWidth-1];

endmodule

FILE: sv/bca_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bca_front
// Temperature front end: X1 from the raw temperature and the magnitudes and
// sign for the temperature divide.
// ----------------------------------------------------------------------------
module bca_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  bca_pkg::cfg_type      cfg,
   input  logic                  in_valid,
   input  logic [15:0]           raw_temp,
   input  logic [18:0]           raw_press,
   output logic                  out_valid,
   output logic [31:0]           out_num,
   output logic [31:0]           out_den,
   output bca_pkg::front_type    out_side
);
   import bca_pkg::*;

   logic [2:0]  vld_ff;
   logic [31:0] d1_ff;
   logic [31:0] x1_ff;
   logic [18:0] up1_ff;
   logic [18:0] up2_ff;
   logic [31:0] num_ff;
   logic [31:0] den_ff;
   front_type   side_ff;
   logic [31:0] num_in;
   logic [31:0] div_in;

   assign num_in = {cfg.mc[20:0], 11'd0};
   assign div_in = x1_ff + cfg.md;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d1_ff        <= {16'd0, raw_temp} - cfg.ac6;
         up1_ff       <= raw_press;
         x1_ff        <= asr(32'(d1_ff * cfg.ac5), 15);
         up2_ff       <= up1_ff;
         num_ff       <= num_in[31] ? 32'(32'd0 - num_in) : num_in;
         den_ff       <= div_in[31] ? 32'(32'd0 - div_in) : div_in;
         side_ff.x1   <= x1_ff;
         side_ff.up   <= up2_ff;
         side_ff.neg  <= num_in[31] ^ div_in[31];
         side_ff.dz   <= div_in == 32'd0;
      end
   end

   assign out_valid = vld_ff[2];
   assign out_num   = num_ff;
   assign out_den   = den_ff;
   assign out_side  = side_ff;

endmodule

FILE: sv/bca_press.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bca_press
// B5, temperature, B6 through B4 and B7, and the operands of the pressure
// divide.
// ----------------------------------------------------------------------------
module bca_press (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  bca_pkg::cfg_type      cfg,
   input  logic                  in_valid,
   input  logic [31:0]           in_quo,
   input  bca_pkg::front_type    in_side,
   output logic                  out_valid,
   output logic [31:0]           out_num,
   output logic [31:0]           out_den,
   output bca_pkg::mid_type      out_side
);
   import bca_pkg::*;

   logic [7:0]  vld_ff;
   front_type   sd_ff [7];
   logic [15:0] tmp_ff [2:7];
   logic [31:0] b5_ff;
   logic [31:0] b6_ff;
   logic [31:0] sq_ff;
   logic [31:0] x2a_ff;
   logic [31:0] x1b_ff;
   logic [31:0] x1a_ff;
   logic [31:0] x2b_ff;
   logic [31:0] x2a4_ff;
   logic [31:0] x1b4_ff;
   logic [31:0] b3_ff;
   logic [31:0] t_ff;
   logic [31:0] b4_ff;
   logic [31:0] bd_ff;
   logic [31:0] b7_ff;
   logic [31:0] b4d_ff;
   logic        b4z_ff;
   logic [31:0] num_ff;
   logic [31:0] den_ff;
   mid_type     side_ff;
   logic [31:0] b3_pre;
   logic [31:0] b3_in;

   assign b3_pre = 32'({cfg.ac1[29:0], 2'b00} + x1a_ff + x2a4_ff);
   assign b3_in  = asr(32'(32'(b3_pre << cfg.oss) + 32'd2), 2);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[6:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sd_ff[0] <= in_side;
         for (int i = 1; i < 7; i++) begin
            sd_ff[i] <= sd_ff[i-1];
         end
         for (int i = 3; i < 8; i++) begin
            tmp_ff[i] <= tmp_ff[i-1];
         end
         b5_ff     <= in_side.x1 + (in_side.neg ? 32'(32'd0 - in_quo) : in_quo);
         tmp_ff[2] <= sat_temp(asr(32'(b5_ff + 32'd8), 4));
         b6_ff     <= b5_ff - 32'd4000;
         sq_ff     <= asr(32'(b6_ff * b6_ff), 12);
         x2a_ff    <= asr(32'(cfg.ac2 * b6_ff), 11);
         x1b_ff    <= asr(32'(cfg.ac3 * b6_ff), 13);
         x1a_ff    <= asr(32'(cfg.b2 * sq_ff), 11);
         x2b_ff    <= asr(32'(cfg.b1 * sq_ff), 16);
         x2a4_ff   <= x2a_ff;
         x1b4_ff   <= x1b_ff;
         b3_ff     <= b3_in;
         t_ff      <= asr(32'(x1b4_ff + x2b_ff + 32'd2), 2) + 32'd32768;
         b4_ff     <= 32'(cfg.ac4 * t_ff) >> 15;
         bd_ff     <= {13'd0, sd_ff[4].up} - b3_ff;
         b7_ff     <= 32'(bd_ff * (32'd50000 >> cfg.oss));
         b4d_ff    <= b4_ff;
         b4z_ff    <= b4_ff == 32'd0;
         num_ff    <= b7_ff[31] ? b7_ff : {b7_ff[30:0], 1'b0};
         den_ff    <= b4d_ff;
         side_ff.temp <= tmp_ff[7];
         side_ff.dz   <= sd_ff[6].dz;
         side_ff.b4z  <= b4z_ff;
         side_ff.dbl  <= b7_ff[31];
      end
   end

   assign out_valid = vld_ff[7];
   assign out_num   = num_ff;
   assign out_den   = den_ff;
   assign out_side  = side_ff;

endmodule

FILE: sv/bca_alt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bca_alt
// Pressure correction, altitude polynomial, saturation and the result
// register.
// ----------------------------------------------------------------------------
module bca_alt (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  bca_pkg::cfg_type      cfg,
   input  logic                  in_valid,
   input  logic [31:0]           in_quo,
   input  bca_pkg::mid_type      in_side,
   output logic                  out_valid,
   output logic [15:0]           temp_decideg,
   output logic [19:0]           press_pa,
   output logic [24:0]           alt_mm,
   output logic                  divide_fault
);
   import bca_pkg::*;

   localparam logic [31:0] KNeg7357 = 32'hFFFF_E343;

   logic [7:0]  vld_ff;
   mid_type     sm_ff [7];
   logic [31:0] p1_ff;
   logic [31:0] p2_ff;
   logic [31:0] p3_ff;
   logic [31:0] sqp_ff;
   logic [31:0] x2_ff;
   logic [31:0] x2b_ff;
   logic [31:0] x1_ff;
   logic [31:0] p4_ff;
   logic [31:0] moo_ff;
   logic [19:0] press5_ff;
   logic [19:0] press6_ff;
   logic [19:0] press7_ff;
   logic [31:0] moo2_ff;
   logic [31:0] t1_ff;
   logic [31:0] m64_ff;
   logic [31:0] m2_ff;
   logic [31:0] moo6_ff;
   logic [31:0] m3_ff;
   logic [31:0] base_ff;
   logic [31:0] moo7_ff;
   logic [15:0] temp_ff;
   logic [19:0] press_ff;
   logic [24:0] alt_ff;
   logic        fault_ff;
   logic [31:0] a8;
   logic [31:0] extra;
   logic [31:0] alt_in;

   assign a8    = asr(p1_ff, 8);
   assign extra = asr(moo7_ff, 12) + asr(moo7_ff, 17) + asr(moo7_ff, 18)
                + asr(m3_ff, 11) + asr(m3_ff, 13) + asr(m3_ff, 17)
                + asr(m3_ff, 18) + asr(m3_ff, 21);
   assign alt_in = base_ff + (cfg.ep ? extra : 32'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[6:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sm_ff[0] <= in_side;
         for (int i = 1; i < 7; i++) begin
            sm_ff[i] <= sm_ff[i-1];
         end
         p1_ff     <= in_side.dbl ? {in_quo[30:0], 1'b0} : in_quo;
         sqp_ff    <= 32'(a8 * a8);
         x2_ff     <= asr(32'(KNeg7357 * p1_ff), 16);
         p2_ff     <= p1_ff;
         x1_ff     <= asr(32'(sqp_ff * 32'd3038), 16);
         x2b_ff    <= x2_ff;
         p3_ff     <= p2_ff;
         p4_ff     <= p3_ff + asr(32'(x1_ff + x2b_ff + 32'd3791), 4);
         moo_ff    <= 32'd95000 - p4_ff;
         press5_ff <= sat_press(p4_ff);
         moo2_ff   <= 32'(moo_ff * moo_ff);
         t1_ff     <= asr(32'(32'd22455 * moo_ff), 8);
         m64_ff    <= asr(moo_ff, 6);
         m2_ff     <= 32'(asr(moo_ff, 6) * asr(moo_ff, 6));
         moo6_ff   <= moo_ff;
         press6_ff <= press5_ff;
         m3_ff     <= 32'(m2_ff * m64_ff);
         base_ff   <= 32'd540418 + t1_ff + asr(moo2_ff, 12) + asr(moo2_ff, 13)
                    + asr(moo2_ff, 17);
         moo7_ff   <= moo6_ff;
         press7_ff <= press6_ff;
         if (sm_ff[6].dz) begin
            temp_ff  <= '0;
            press_ff <= '0;
            alt_ff   <= '0;
            fault_ff <= 1'b1;
         end else if (sm_ff[6].b4z) begin
            temp_ff  <= sm_ff[6].temp;
            press_ff <= '0;
            alt_ff   <= '0;
            fault_ff <= 1'b1;
         end else begin
            temp_ff  <= sm_ff[6].temp;
            press_ff <= press7_ff;
            alt_ff   <= sat_alt(alt_in);
            fault_ff <= 1'b0;
         end
      end
   end

   assign out_valid    = vld_ff[7];
   assign temp_decideg = temp_ff;
   assign press_pa     = press_ff;
   assign alt_mm       = alt_ff;
   assign divide_fault = fault_ff;

endmodule

FILE: sv/barometric_compensation_altitude.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barometric_compensation_altitude
// Pressure and temperature compensation with standard-atmosphere altitude.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  raw_temp, raw_press
//   rsp      out        rsp_valid / rsp_stall  temp_decideg, press_pa, alt_mm,
//                                              divide_fault
//   csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// One beat enters per cycle while the result is not stalled; the path is the two 32-stage
// dividers plus 19 arithmetic stages.
// The whole pipeline holds while a result waits and rsp_stall is high.
// Synchronous reset clears valid bits and the configuration registers.
// ----------------------------------------------------------------------------
module barometric_compensation_altitude (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [15:0]                         req_raw_temp,
   input  logic [18:0]                         req_raw_press,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [15:0]                  rsp_temp_decideg,
   output logic [19:0]                         rsp_press_pa,
   output logic signed [24:0]                  rsp_alt_mm,
   output logic                                rsp_divide_fault,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bca_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [63:0]                         csr_data
);
   import bca_pkg::*;

   logic [1:0]  oss_ff;
   logic [63:0] cal_a_ff;
   logic [63:0] cal_b_ff;
   logic [31:0] cal_c_ff;
   logic        ep_ff;
   cfg_type     cfg;
   logic        en;

   logic        fr_valid;
   logic [31:0] fr_num;
   logic [31:0] fr_den;
   front_type   fr_side;
   logic        da_valid;
   logic [31:0] da_quo;
   front_type   da_side;
   logic        pr_valid;
   logic [31:0] pr_num;
   logic [31:0] pr_den;
   mid_type     pr_side;
   logic        db_valid;
   logic [31:0] db_quo;
   mid_type     db_side;
   logic [15:0] temp_w;
   logic [24:0] alt_w;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         oss_ff   <= '0;
         cal_a_ff <= '0;
         cal_b_ff <= '0;
         cal_c_ff <= '0;
         ep_ff    <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CsrOss:   oss_ff   <= csr_data[1:0];
            CsrCalA:  cal_a_ff <= csr_data;
            CsrCalB:  cal_b_ff <= csr_data;
            CsrCalC:  cal_c_ff <= csr_data[31:0];
            CsrExtra: ep_ff    <= csr_data[0];
            default:  ;
         endcase
      end
   end

   always_comb begin
      cfg.oss = oss_ff;
      cfg.ep  = ep_ff;
      cfg.ac1 = {{16{cal_a_ff[63]}}, cal_a_ff[63:48]};
      cfg.ac2 = {{16{cal_a_ff[47]}}, cal_a_ff[47:32]};
      cfg.ac3 = {{16{cal_a_ff[31]}}, cal_a_ff[31:16]};
      cfg.ac4 = {16'd0, cal_a_ff[15:0]};
      cfg.ac5 = {16'd0, cal_b_ff[63:48]};
      cfg.ac6 = {16'd0, cal_b_ff[47:32]};
      cfg.b1  = {{16{cal_b_ff[31]}}, cal_b_ff[31:16]};
      cfg.b2  = {{16{cal_b_ff[15]}}, cal_b_ff[15:0]};
      cfg.mc  = {{16{cal_c_ff[31]}}, cal_c_ff[31:16]};
      cfg.md  = {{16{cal_c_ff[15]}}, cal_c_ff[15:0]};
   end

   // hold everything while the result register is full and stalled
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   bca_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .raw_temp  (req_raw_temp),
      .raw_press (req_raw_press),
      .out_valid (fr_valid),
      .out_num   (fr_num),
      .out_den   (fr_den),
      .out_side  (fr_side)
   );

   bca_div #(.SideWidth($bits(front_type))) u_div_temp (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .in_num    (fr_num),
      .in_den    (fr_den),
      .in_side   (fr_side),
      .out_valid (da_valid),
      .out_quo   (da_quo),
      .out_side  (da_side)
   );

   bca_press u_press (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg),
      .in_valid  (da_valid),
      .in_quo    (da_quo),
      .in_side   (da_side),
      .out_valid (pr_valid),
      .out_num   (pr_num),
      .out_den   (pr_den),
      .out_side  (pr_side)
   );

   bca_div #(.SideWidth($bits(mid_type))) u_div_press (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (pr_valid),
      .in_num    (pr_num),
      .in_den    (pr_den),
      .in_side   (pr_side),
      .out_valid (db_valid),
      .out_quo   (db_quo),
      .out_side  (db_side)
   );

   bca_alt u_alt (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .cfg          (cfg),
      .in_valid     (db_valid),
      .in_quo       (db_quo),
      .in_side      (db_side),
      .out_valid    (rsp_valid),
      .temp_decideg (temp_w),
      .press_pa     (rsp_press_pa),
      .alt_mm       (alt_w),
      .divide_fault (rsp_divide_fault)
   );

   assign rsp_temp_decideg = $signed(temp_w);
   assign rsp_alt_mm       = $signed(alt_w);

endmodule

FILE: sv/bca_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bca_checker
// Port-level checks for the compensation pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module bca_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [15:0]                  rsp_temp_decideg,
   input logic [19:0]                         rsp_press_pa,
   input logic signed [24:0]                  rsp_alt_mm,
   input logic                                rsp_divide_fault
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_temp_decideg) && $stable(rsp_press_pa)
         && $stable(rsp_alt_mm) && $stable(rsp_divide_fault))
      else $error("stalled result beat changed");

   a_back_pressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while output stalled");

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_fault |-> rsp_press_pa == 20'd0 && rsp_alt_mm == 25'sd0)
      else $error("fault beat carries pressure or altitude");

endmodule

bind barometric_compensation_altitude bca_checker u_bca_checker (.*);
